// ----- design/assert_macros.svh -----
// Assertion macros shared by the mirror/sepia pixel pipeline RTL.
// Each macro expects clk and rst_n in the scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define MSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition leads to another one in the following cycle.
`define MSP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- design/msp_pkg.sv -----
// Shared types, constants and register codes of the mirror/sepia pixel pipeline.
// Used by every module of the block; depends on nothing.
`default_nettype none

package msp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ADDR_W     = COL_W + 1;
    localparam int CNT_W      = COL_W + 1;
    localparam int LW_W       = 11;
    localparam int LW_RESET   = 640;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPIA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = FIFO_PTR_W + 1;

    localparam int CHAN_MAX  = 255;
    localparam int FRAC_W    = 16;
    localparam int SUM_W     = 25;

    localparam int COEF_RR = 25756;
    localparam int COEF_RG = 50397;
    localparam int COEF_RB = 12386;
    localparam int COEF_GR = 22872;
    localparam int COEF_GG = 44958;
    localparam int COEF_GB = 11010;
    localparam int COEF_BR = 17826;
    localparam int COEF_BG = 34996;
    localparam int COEF_BB = 8585;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic   last;
        pixel_t pixel;
    } out_beat_t;

endpackage

`default_nettype wire

// ----- design/msp_row_ram.sv -----
// Two-bank line store: one write port, one read port with registered read data.
// Depends on msp_pkg for the pixel type and address width.
`default_nettype none

module msp_row_ram (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [msp_pkg::ADDR_W-1:0] wr_addr,
    input  wire msp_pkg::pixel_t            wr_data,
    input  wire logic                       rd_en,
    input  wire logic [msp_pkg::ADDR_W-1:0] rd_addr,
    output msp_pkg::pixel_t                 rd_data
);
    import msp_pkg::*;

    pixel_t mem [2**ADDR_W];
    pixel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/msp_sepia.sv -----
// Sepia color stage: registered matrix sums, then truncation and saturation; bypassed when off.
// Depends on msp_pkg for coefficients, pixel and beat types.
`default_nettype none

module msp_sepia (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sepia_en,
    input  wire logic               in_valid,
    input  wire msp_pkg::out_beat_t in_beat,
    output logic                    out_valid,
    output msp_pkg::out_beat_t      out_beat
);
    import msp_pkg::*;

    logic             valid_reg;
    logic             sepia_reg;
    out_beat_t        beat_reg;
    logic [SUM_W-1:0] sum_r_reg;
    logic [SUM_W-1:0] sum_g_reg;
    logic [SUM_W-1:0] sum_b_reg;
    logic [SUM_W-1:0] sum_r_next;
    logic [SUM_W-1:0] sum_g_next;
    logic [SUM_W-1:0] sum_b_next;
    logic [SUM_W-1:0] red_w;
    logic [SUM_W-1:0] green_w;
    logic [SUM_W-1:0] blue_w;

    function automatic logic [7:0] sat_channel(input logic [SUM_W-1:0] sum);
        logic [SUM_W-FRAC_W-1:0] v;
        begin
            v = sum[SUM_W-1:FRAC_W];
            sat_channel = (v > (SUM_W-FRAC_W)'(CHAN_MAX)) ? 8'(CHAN_MAX) : v[7:0];
        end
    endfunction

    always_comb
    begin
        red_w      = SUM_W'(in_beat.pixel.red);
        green_w    = SUM_W'(in_beat.pixel.green);
        blue_w     = SUM_W'(in_beat.pixel.blue);
        sum_r_next = SUM_W'(COEF_RR) * red_w + SUM_W'(COEF_RG) * green_w
                   + SUM_W'(COEF_RB) * blue_w;
        sum_g_next = SUM_W'(COEF_GR) * red_w + SUM_W'(COEF_GG) * green_w
                   + SUM_W'(COEF_GB) * blue_w;
        sum_b_next = SUM_W'(COEF_BR) * red_w + SUM_W'(COEF_BG) * green_w
                   + SUM_W'(COEF_BB) * blue_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sepia_reg <= sepia_en;
        beat_reg  <= in_beat;
        sum_r_reg <= sum_r_next;
        sum_g_reg <= sum_g_next;
        sum_b_reg <= sum_b_next;
    end

    always_comb
    begin
        out_beat = beat_reg;
        if (sepia_reg)
        begin
            out_beat.pixel.red   = sat_channel(sum_r_reg);
            out_beat.pixel.green = sat_channel(sum_g_reg);
            out_beat.pixel.blue  = sat_channel(sum_b_reg);
        end
    end

    assign out_valid = valid_reg;

endmodule

`default_nettype wire

// ----- design/msp_out_fifo.sv -----
// Four-entry output queue that decouples the pipeline from the master side.
// Depends on msp_pkg for the beat type and depth, and on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module msp_out_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_valid,
    input  wire msp_pkg::out_beat_t wr_data,
    output logic                    rd_valid,
    input  wire logic               rd_ready,
    output msp_pkg::out_beat_t      rd_data
);
    import msp_pkg::*;

    out_beat_t             entries [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [OCC_W-1:0]      count_reg;
    logic [OCC_W-1:0]      count_next;
    logic                  rd_fire;

    assign rd_valid = (count_reg != '0);
    assign rd_fire  = rd_valid & rd_ready;
    assign rd_data  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_valid ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_fire ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OCC_W'(wr_valid) - OCC_W'(rd_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            entries[wr_ptr_reg] <= wr_data;
        end
    end

    `MSP_ASSERT(a_no_overflow, !(wr_valid && !rd_fire && count_reg == OCC_W'(FIFO_DEPTH)), "output queue overflow")
    `MSP_ASSERT(a_count_bound, count_reg <= OCC_W'(FIFO_DEPTH), "output queue count out of range")
    `MSP_ASSERT(a_ptr_gap, (wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_PTR_W-1:0], "queue pointers disagree with count")

endmodule

`default_nettype wire

// ----- design/mirror_sepia_pixel_pipeline_unit.sv -----
// Mirror and sepia pixel pipeline: row sequencing, line store, sepia stage, output queue.
// Depends on msp_pkg, msp_row_ram, msp_sepia, msp_out_fifo and assert_macros.svh.
//
// Takes one transaction per clock on the slave side when the output queue has room; a
// result passes stage one, the sepia stage and the output queue. The rate is set by the
// line store, one read and one write per cycle, and by a four-entry output queue whose
// occupancy (including items still in the pipeline) drives s_axis_tready, so master-side
// stalls never reach the slave side combinationally. With mirroring on, output lags one
// row; drain transactions read out the pending row. No clearing pass follows reset. The
// user must write configuration only while the block is idle; the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module mirror_sepia_pixel_pipeline_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire msp_pkg::pixel_t               s_axis_tdata,  // red_in, green_in, blue_in
    input  wire logic                          s_axis_tuser,  // kind
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output msp_pkg::pixel_t                    m_axis_tdata,  // red_out, green_out, blue_out
    output logic                               m_axis_tlast,  // row_end
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [msp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [msp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import msp_pkg::*;

    logic             mirror_reg;
    logic             sepia_reg;
    logic [LW_W-1:0]  lw_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             bank_reg;
    logic             bank_next;
    logic [CNT_W-1:0] pend_reg;
    logic [CNT_W-1:0] pend_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_from_mem_reg;
    logic             s1_last_reg;
    logic             s1_last_next;
    pixel_t           s1_pix_reg;

    logic [31:0]      lw_w32;
    logic [CNT_W-1:0] eff_w;
    logic [CNT_W-1:0] col_plus;
    logic [CNT_W-1:0] pend_dec;
    logic             done;
    logic             has_pend;
    logic             is_drain;
    logic             use_mem;
    logic             emit;
    logic             in_fire;
    logic             out_fire;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    pixel_t            rd_data;

    out_beat_t        s1_beat;
    logic             sep_valid;
    out_beat_t        sep_beat;
    out_beat_t        q_beat;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (occ_reg < OCC_W'(FIFO_DEPTH));
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_fire      = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg <= 1'b0;
            sepia_reg  <= 1'b0;
            lw_reg     <= LW_W'(LW_RESET);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIRROR: mirror_reg <= cfg_data[0];
                CFG_SEPIA:  sepia_reg  <= cfg_data[0];
                CFG_WIDTH:  lw_reg     <= cfg_data[LW_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        lw_w32 = 32'(lw_reg);
        if (lw_w32 == 32'd0)
        begin
            eff_w = CNT_W'(1);
        end
        else if (lw_w32 > 32'(MAX_WIDTH))
        begin
            eff_w = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = CNT_W'(lw_w32);
        end
        col_plus = CNT_W'(col_reg) + CNT_W'(1);
        pend_dec = pend_reg - CNT_W'(1);
        done     = (col_plus >= eff_w);
        has_pend = (pend_reg != '0);
        is_drain = (s_axis_tuser == KIND_DRAIN);
        use_mem  = (is_drain || mirror_reg) && has_pend;
        emit     = use_mem || (!is_drain && !mirror_reg);
    end

    always_comb
    begin
        rd_en   = in_fire & use_mem;
        rd_addr = {~bank_reg, pend_dec[COL_W-1:0]};
        wr_en   = in_fire & ~is_drain;
        wr_addr = {bank_reg, col_reg};
    end

    always_comb
    begin
        col_next      = col_reg;
        bank_next     = bank_reg;
        pend_next     = pend_reg;
        s1_valid_next = in_fire & emit;
        s1_last_next  = use_mem ? (pend_reg == CNT_W'(1)) : done;
        if (in_fire)
        begin
            if (use_mem)
            begin
                pend_next = pend_dec;
            end
            if (!is_drain)
            begin
                if (done)
                begin
                    col_next = '0;
                    if (mirror_reg)
                    begin
                        bank_next = ~bank_reg;
                        pend_next = eff_w;
                    end
                end
                else
                begin
                    col_next = col_plus[COL_W-1:0];
                end
            end
        end
        occ_next = occ_reg + OCC_W'(s1_valid_next) - OCC_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            bank_reg     <= 1'b0;
            pend_reg     <= '0;
            occ_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            bank_reg     <= bank_next;
            pend_reg     <= pend_next;
            occ_reg      <= occ_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_from_mem_reg <= use_mem;
        s1_last_reg     <= s1_last_next;
        s1_pix_reg      <= s_axis_tdata;
    end

    msp_row_ram u_row_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        s1_beat.pixel = s1_from_mem_reg ? rd_data : s1_pix_reg;
        s1_beat.last  = s1_last_reg;
    end

    msp_sepia u_sepia (
        .clk       (clk),
        .rst_n     (rst_n),
        .sepia_en  (sepia_reg),
        .in_valid  (s1_valid_reg),
        .in_beat   (s1_beat),
        .out_valid (sep_valid),
        .out_beat  (sep_beat)
    );

    msp_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (sep_valid),
        .wr_data  (sep_beat),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_data  (q_beat)
    );

    assign m_axis_tdata = q_beat.pixel;
    assign m_axis_tlast = q_beat.last;

    `MSP_ASSERT(a_occ_bound, occ_reg <= OCC_W'(FIFO_DEPTH), "in-flight count out of range")
    `MSP_ASSERT(a_pend_bound, pend_reg <= CNT_W'(MAX_WIDTH), "pending count exceeds row size")
    `MSP_ASSERT(a_banks_apart, !(rd_en && wr_en && rd_addr[ADDR_W-1] == wr_addr[ADDR_W-1]), "read and write hit the same bank")
    `MSP_ASSERT_NEXT(a_mem_to_s1, rd_en, s1_valid_reg && s1_from_mem_reg, "store read lost before stage one")
    `MSP_ASSERT_NEXT(a_pend_drop, in_fire && use_mem && !(wr_en && done && mirror_reg), pend_reg == $past(pend_reg) - CNT_W'(1), "pending count did not step down")

endmodule

`default_nettype wire
